// ===== rtl/core/ssmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmr_pkg
// Shared types and constants for the scheduled stereo mute ramp.
// ----------------------------------------------------------------------------
package ssmr_pkg;

   localparam int BLOCK_LEN = 128;
   localparam int FADE_LEN  = 441;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 25;
   localparam int STEP_W   = 26;
   localparam int POS_W    = 48;
   localparam int FADE_W   = 16;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   localparam int OFFSET_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(64'd1 << 24);

   // reciprocal of the fade length, scaled by 2^DIV_SHIFT
   localparam int DIV_SHIFT = 25;
   localparam int RECIP_W   = 26;
   localparam logic [RECIP_W-1:0] FADE_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / FADE_LEN);
   localparam logic [FADE_W-1:0]  FADE_CONST = FADE_W'(FADE_LEN);

   localparam logic [POS_W:0]      BLOCK_SPAN = (POS_W + 1)'(BLOCK_LEN);
   localparam logic [OFFSET_W-1:0] OFFSET_LAST = OFFSET_W'(BLOCK_LEN - 1);

   // request codes
   localparam logic [2:0] KIND_SAMPLE  = 3'd0;
   localparam logic [2:0] KIND_ENABLE  = 3'd1;
   localparam logic [2:0] KIND_DISABLE = 3'd2;
   localparam logic [2:0] KIND_TOGGLE  = 3'd3;
   localparam logic [2:0] KIND_ONSET   = 3'd4;
   localparam logic [2:0] KIND_RELEASE = 3'd5;

   typedef struct packed {
      logic [2:0]                 req_type;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic [POS_W-1:0]           when_sample;
   } ssmr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       muted;
   } ssmr_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIFF,
      ST_RECIP,
      ST_BACK,
      ST_FIX,
      ST_GAIN,
      ST_MUL,
      ST_EMIT
   } ssmr_state_type;

   typedef struct packed {
      logic mul_en;
      logic emit;
      logic muted;
   } ssmr_ctrl_type;

endpackage

// ===== rtl/core/ssmr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmr_lane
// One channel: holds its sample, multiplies by the shared gain, then
// truncates toward zero and saturates to 16 bits.
// ----------------------------------------------------------------------------
module ssmr_lane (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic signed [ssmr_pkg::SAMPLE_W-1:0] sample,
   input  logic                                 mul_en,
   input  logic [ssmr_pkg::GAIN_W-1:0]          gain,
   output logic signed [ssmr_pkg::SAMPLE_W-1:0] result
);
   import ssmr_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       neg_ff, neg_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [SAMPLE_W-1:0]        mag;
   logic [PROD_W-25:0]         scaled;

   // magnitude of -32768 is 32768, which still fits unsigned 16 bits
   assign mag = sample_ff[SAMPLE_W-1] ? SAMPLE_W'(-sample_ff) : SAMPLE_W'(sample_ff);

   always_comb begin
      sample_in = load ? sample : sample_ff;
      neg_in    = mul_en ? sample_ff[SAMPLE_W-1] : neg_ff;
      prod_in   = mul_en ? PROD_W'(mag) * PROD_W'(gain) : prod_ff;
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
   end

   assign scaled = prod_ff[PROD_W-1:24];

   always_comb begin
      if (neg_ff) begin
         if (scaled > (PROD_W - 24)'(32768)) begin
            result = -16'sd32768;
         end else begin
            result = SAMPLE_W'(~scaled + 1'b1);
         end
      end else begin
         if (scaled > (PROD_W - 24)'(32767)) begin
            result = 16'sd32767;
         end else begin
            result = SAMPLE_W'(scaled);
         end
      end
   end

endmodule

// ===== rtl/core/ssmr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmr_ctrl
// Mute state, schedule checks at block start, step divider and gain ramp.
// ----------------------------------------------------------------------------
module ssmr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_fire,
   input  ssmr_pkg::ssmr_req_type       req,
   input  logic                         out_free,
   output logic                         busy,
   output logic [ssmr_pkg::GAIN_W-1:0]  gain,
   output ssmr_pkg::ssmr_ctrl_type      ctrl
);
   import ssmr_pkg::*;

   ssmr_state_type state_ff, state_in;

   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic                     target_ff, target_in;
   logic                     engaged_ff, engaged_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [OFFSET_W-1:0]      offset_ff, offset_in;
   logic [POS_W-1:0]         onset_ff, onset_in;
   logic [POS_W-1:0]         release_ff, release_in;

   // divider datapath
   logic [GAIN_W-1:0]        mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [GAIN_W-1:0]        quot_ff, quot_in;
   logic [GAIN_W+FADE_W-1:0] back_ff, back_in;

   logic                          sample_fire;
   logic                          advance;
   logic                          onset_hit, release_hit;
   logic [GAIN_W+RECIP_W-1:0]     recip_prod;
   logic [GAIN_W+FADE_W-1:0]      remainder;
   logic [GAIN_W-1:0]             quot_fixed;
   logic signed [GAIN_W+1:0]      gain_sum;

   function automatic logic in_window(input logic [POS_W-1:0] at,
                                      input logic [POS_W-1:0] pos);
      logic [POS_W:0] window_end;
      window_end = {1'b0, pos} + BLOCK_SPAN;
      return (at != '0) && (at >= pos) && ({1'b0, at} < window_end);
   endfunction

   assign sample_fire = req_fire && (req.req_type == KIND_SAMPLE);
   assign onset_hit   = in_window(onset_ff, pos_ff);
   assign release_hit = in_window(release_ff, pos_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               state_in = (offset_ff == '0) ? ST_CHECK : ST_MUL;
            end
         end
         ST_CHECK: state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_RECIP;
         ST_RECIP: state_in = ST_BACK;
         ST_BACK:  state_in = ST_FIX;
         ST_FIX:   state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      advance     = (state_ff == ST_GAIN) ||
                    ((state_ff == ST_IDLE) && sample_fire && (offset_ff != '0));
      ctrl.mul_en = (state_ff == ST_MUL);
      ctrl.emit   = (state_ff == ST_EMIT) && out_free;
      ctrl.muted  = engaged_ff;
   end

   assign recip_prod = (GAIN_W + RECIP_W)'(mag_ff) * (GAIN_W + RECIP_W)'(FADE_RECIP);
   assign remainder  = (GAIN_W + FADE_W)'(mag_ff) - back_ff;
   // reciprocal quotient is low by at most one
   assign quot_fixed = quot_ff + GAIN_W'(remainder >= (GAIN_W + FADE_W)'(FADE_CONST));
   assign gain_sum   = $signed({2'b00, gain_ff}) + $signed({step_ff[STEP_W-1], step_ff});

   always_comb begin
      gain_in    = gain_ff;
      target_in  = target_ff;
      engaged_in = engaged_ff;
      step_in    = step_ff;
      pos_in     = pos_ff;
      offset_in  = offset_ff;
      onset_in   = onset_ff;
      release_in = release_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      quot_in    = quot_ff;
      back_in    = back_ff;

      if ((state_ff == ST_IDLE) && req_fire) begin
         case (req.req_type)
            KIND_ENABLE: begin
               target_in  = 1'b0;
               engaged_in = 1'b1;
            end
            KIND_DISABLE: begin
               target_in  = 1'b1;
               engaged_in = 1'b0;
            end
            KIND_TOGGLE: begin
               engaged_in = !engaged_ff;
               target_in  = engaged_ff;
            end
            KIND_ONSET:   onset_in   = req.when_sample;
            KIND_RELEASE: release_in = req.when_sample;
            default: ;
         endcase
      end

      // release is checked after onset, so it wins when both fall in the block
      if (state_ff == ST_CHECK) begin
         if (onset_hit) begin
            target_in  = 1'b0;
            engaged_in = 1'b1;
            onset_in   = '0;
         end
         if (release_hit) begin
            target_in  = 1'b1;
            engaged_in = 1'b0;
            release_in = '0;
         end
      end

      if (state_ff == ST_DIFF) begin
         mag_in = target_ff ? (UNITY_GAIN - gain_ff) : gain_ff;
         neg_in = !target_ff;
      end

      if (state_ff == ST_RECIP) begin
         quot_in = recip_prod[DIV_SHIFT +: GAIN_W];
      end

      if (state_ff == ST_BACK) begin
         back_in = (GAIN_W + FADE_W)'(quot_ff) * (GAIN_W + FADE_W)'(FADE_CONST);
      end

      if (state_ff == ST_FIX) begin
         step_in = neg_ff ? -$signed(STEP_W'(quot_fixed)) : $signed(STEP_W'(quot_fixed));
      end

      if (advance) begin
         if (gain_sum < 0) begin
            gain_in = '0;
         end else if (gain_sum > $signed({2'b00, UNITY_GAIN})) begin
            gain_in = UNITY_GAIN;
         end else begin
            gain_in = GAIN_W'(gain_sum);
         end
         pos_in    = pos_ff + 1'b1;
         offset_in = (offset_ff == OFFSET_LAST) ? '0 : offset_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         gain_ff    <= UNITY_GAIN;
         target_ff  <= 1'b1;
         engaged_ff <= 1'b0;
         step_ff    <= '0;
         pos_ff     <= '0;
         offset_ff  <= '0;
         onset_ff   <= '0;
         release_ff <= '0;
      end else begin
         state_ff   <= state_in;
         gain_ff    <= gain_in;
         target_ff  <= target_in;
         engaged_ff <= engaged_in;
         step_ff    <= step_in;
         pos_ff     <= pos_in;
         offset_ff  <= offset_in;
         onset_ff   <= onset_in;
         release_ff <= release_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      back_ff <= back_in;
   end

   assign gain = gain_ff;

endmodule

// ===== rtl/core/scheduled_stereo_mute_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_stereo_mute_ramp
// Click-free stereo mute with block-scheduled onset and release; two
// channel lanes share one ramped gain and a merge stage registers results.
// ----------------------------------------------------------------------------
//  channel   ports                        direction  carries
//  request   req_valid/req_stall/req_data in         command or stereo pair
//  response  rsp_valid/rsp_stall/rsp_data out        scaled pair and mute flag
//
//  the single control sequencer takes commands while idle; a sample pair
//  passes check, diff, recip, back, fix and gain first if it opens a block,
//  where the divider sets the step, then the lane multiply and emit states.
//  reset is synchronous; no clearing pass, the block is ready right away.
//  a stalled response holds its register; the sequencer waits for it to free.
// ----------------------------------------------------------------------------
module scheduled_stereo_mute_ramp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ssmr_pkg::ssmr_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ssmr_pkg::ssmr_rsp_type rsp_data
);
   import ssmr_pkg::*;

   ssmr_ctrl_type              ctrl;
   logic                       req_fire;
   logic                       lane_load;
   logic                       out_free;
   logic [GAIN_W-1:0]          gain_w;
   logic signed [SAMPLE_W-1:0] left_w, right_w;

   ssmr_rsp_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   assign req_fire  = req_valid && !req_stall;
   assign lane_load = req_fire && (req_data.req_type == KIND_SAMPLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   ssmr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req      (req_data),
      .out_free (out_free),
      .busy     (req_stall),
      .gain     (gain_w),
      .ctrl     (ctrl)
   );

   ssmr_lane u_lane_left (
      .clock  (clock),
      .load   (lane_load),
      .sample (req_data.left_in),
      .mul_en (ctrl.mul_en),
      .gain   (gain_w),
      .result (left_w)
   );

   ssmr_lane u_lane_right (
      .clock  (clock),
      .load   (lane_load),
      .sample (req_data.right_in),
      .mul_en (ctrl.mul_en),
      .gain   (gain_w),
      .result (right_w)
   );

   // merge both lanes with the mute flag into the response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.emit) begin
         rsp_in.left_out  = left_w;
         rsp_in.right_out = right_w;
         rsp_in.muted     = ctrl.muted;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sample_blocks_next: assert property (@(posedge clock) disable iff (reset)
      lane_load |=> req_stall)
      else $error("request taken while a sample pair is in flight");

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> out_free)
      else $error("response register overwritten while stalled");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_w <= UNITY_GAIN)
      else $error("gain above unity");

   a_emit_when_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> req_stall)
      else $error("response produced while idle");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scheduled stereo mute ramp. A short table of
// directed requests covers the sample extremes, every command, cancel and
// overwrite of schedules and the unused codes; random traffic then drives
// pairs, mute commands and onset/release schedules mostly near the running
// position. A ramp predictor or typed row gives the expected pairs, checked
// in order, in phases of sender gaps, receiver stalls and two long hold-offs.
// ----------------------------------------------------------------------------
module tb;
   import ssmr_pkg::*;

   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   localparam int RAND_ITEMS   = 1130;
   localparam int PHASES       = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_CAP   = 100;
   localparam int DIR_ROWS     = 22;

   localparam longint SAT_POS     = 32767;
   localparam longint SAT_NEG_MAG = 32768;

   localparam int SEND_IDLE_PCT [PHASES] = '{0, 52, 0, 23};
   localparam int RSP_STALL_PCT [PHASES] = '{0, 0, 52, 23};

   typedef struct packed {
      ssmr_req_type req;
      logic         typed;
      ssmr_rsp_type want;
   } dir_row_type;

   // request fields | expected pair typed in | expected left, right, muted
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      {KIND_SAMPLE,  16'h7fff, 16'h8000, 48'h0, 1'b1, 16'h7fff, 16'h8000, 1'b0},
      {KIND_SAMPLE,  16'h8000, 16'h7fff, 48'h0, 1'b1, 16'h8000, 16'h7fff, 1'b0},
      {KIND_SAMPLE,  16'h0000, 16'hffff, 48'h0, 1'b1, 16'h0000, 16'hffff, 1'b0},
      // mute engages at once, gain holds until the next block start
      {KIND_ENABLE,  16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SAMPLE,  16'h03e8, 16'hfc18, 48'h0, 1'b1, 16'h03e8, 16'hfc18, 1'b1},
      {KIND_DISABLE, 16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SAMPLE,  16'h1234, 16'hedcb, 48'h0, 1'b1, 16'h1234, 16'hedcb, 1'b0},
      {KIND_TOGGLE,  16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SAMPLE,  16'h5555, 16'haaaa, 48'h0, 1'b1, 16'h5555, 16'haaaa, 1'b1},
      {KIND_TOGGLE,  16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SAMPLE,  16'h7fff, 16'h8000, 48'h0, 1'b1, 16'h7fff, 16'h8000, 1'b0},
      // far schedules, then cancelled
      {KIND_ONSET,   16'h0000, 16'h0000, 48'hffff_ffff_ffff,
       1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_RELEASE, 16'h0000, 16'h0000, 48'hffff_ffff_ffff,
       1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_ONSET,   16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_RELEASE, 16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // unused codes are dropped
      {KIND_SPARE_A, 16'hffff, 16'hffff, 48'hffff_ffff_ffff,
       1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SPARE_B, 16'h0000, 16'h0000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      // overwritten onset, then onset and release landing in one block
      {KIND_ONSET,   16'h0000, 16'h0000, 48'd50000, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_ONSET,   16'h0000, 16'h0000, 48'd130, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_RELEASE, 16'h0000, 16'h0000, 48'd200, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SAMPLE,  16'h4000, 16'hc000, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0},
      {KIND_SAMPLE,  16'h0001, 16'hffff, 48'h0, 1'b0, 16'h0000, 16'h0000, 1'b0}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ssmr_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   ssmr_rsp_type rsp_data;

   ssmr_rsp_type pair_expect_q [$];
   int           fail_count    = 0;
   int           cycle_count   = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_req      = 0;
   int           hold_done     = 0;

   // predictor state
   logic [GAIN_W-1:0]        gain_q;
   logic signed [STEP_W-1:0] step_q;
   logic                     unity_tgt;
   logic                     engaged_q;
   logic [POS_W-1:0]         pos_q;
   logic [OFFSET_W-1:0]      blk_off;
   logic [POS_W-1:0]         onset_at;
   logic [POS_W-1:0]         release_at;

   scheduled_stereo_mute_ramp u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void ramp_reset();
      gain_q     = UNITY_GAIN;
      step_q     = '0;
      unity_tgt  = 1'b1;
      engaged_q  = 1'b0;
      pos_q      = '0;
      blk_off    = '0;
      onset_at   = '0;
      release_at = '0;
   endfunction

   // window is [pos, pos + BLOCK_LEN) with no wrap
   function automatic logic due_now(input logic [POS_W-1:0] at);
      logic [POS_W:0] span_end;
      span_end = {1'b0, pos_q} + BLOCK_SPAN;
      return (at != '0) && (at >= pos_q) && ({1'b0, at} < span_end);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] scale_sample(
      input logic signed [SAMPLE_W-1:0] s
   );
      longint mag;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      mag = (mag * longint'(gain_q)) >>> 24;
      if (s < 0) begin
         return (mag > SAT_NEG_MAG) ? 16'sh8000 : SAMPLE_W'(-mag);
      end
      return (mag > SAT_POS) ? 16'sh7fff : SAMPLE_W'(mag);
   endfunction

   function automatic logic ramp_predict(input ssmr_req_type r, output ssmr_rsp_type res);
      longint diff;
      longint g;
      res = '0;
      case (r.req_type)
         KIND_ENABLE: begin
            unity_tgt = 1'b0;
            engaged_q = 1'b1;
            return 1'b0;
         end
         KIND_DISABLE: begin
            unity_tgt = 1'b1;
            engaged_q = 1'b0;
            return 1'b0;
         end
         KIND_TOGGLE: begin
            engaged_q = ~engaged_q;
            unity_tgt = ~engaged_q;
            return 1'b0;
         end
         KIND_ONSET: begin
            onset_at = r.when_sample;
            return 1'b0;
         end
         KIND_RELEASE: begin
            release_at = r.when_sample;
            return 1'b0;
         end
         KIND_SAMPLE: ;
         default: return 1'b0;
      endcase

      if (blk_off == '0) begin
         if (due_now(onset_at)) begin
            unity_tgt = 1'b0;
            engaged_q = 1'b1;
            onset_at  = '0;
         end
         if (due_now(release_at)) begin
            unity_tgt  = 1'b1;
            engaged_q  = 1'b0;
            release_at = '0;
         end
         diff = -longint'(gain_q);
         if (unity_tgt) diff += longint'(UNITY_GAIN);
         step_q = STEP_W'(diff / FADE_LEN);
      end

      g = longint'(gain_q) + longint'(step_q);
      if (g < 0) g = 0;
      if (g > longint'(UNITY_GAIN)) g = longint'(UNITY_GAIN);
      gain_q = GAIN_W'(g);

      res.left_out  = scale_sample(r.left_in);
      res.right_out = scale_sample(r.right_in);
      res.muted     = engaged_q;

      pos_q   = pos_q + 1'b1;
      blk_off = (blk_off == OFFSET_LAST) ? '0 : blk_off + 1'b1;
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] extreme_sample();
      case ($urandom_range(0, 3))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   task automatic pick_random_req(output ssmr_req_type r, output logic counted);
      int roll;
      r             = '0;
      r.left_in     = SAMPLE_W'($urandom);
      r.right_in    = SAMPLE_W'($urandom);
      r.when_sample = POS_W'({$urandom, $urandom});
      counted       = 1'b1;
      roll          = $urandom_range(0, 99);
      if (roll < 78) begin
         r.req_type = KIND_SAMPLE;
         if ($urandom_range(0, 9) == 0) r.left_in = extreme_sample();
         if ($urandom_range(0, 9) == 0) r.right_in = extreme_sample();
      end else if (roll < 86) begin
         case ($urandom_range(0, 2))
            0: r.req_type = KIND_ENABLE;
            1: r.req_type = KIND_DISABLE;
            default: r.req_type = KIND_TOGGLE;
         endcase
      end else if (roll < 96) begin
         r.req_type = ($urandom_range(0, 1) != 0) ? KIND_ONSET : KIND_RELEASE;
         roll = $urandom_range(0, 19);
         // mostly land within the next few blocks, some cancels, rest anywhere
         if (roll < 14) begin
            r.when_sample = pos_q + POS_W'($urandom_range(0, 3 * BLOCK_LEN));
         end else if (roll < 17) begin
            r.when_sample = '0;
         end
      end else begin
         r.req_type = ($urandom_range(0, 1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
         counted    = 1'b0;
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_req(input ssmr_req_type r, input logic typed,
                           input ssmr_rsp_type want);
      ssmr_rsp_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      if (ramp_predict(r, res)) pair_expect_q.push_back(typed ? want : res);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pair_expect_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_done) begin
            hold_done++;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      ssmr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pair_expect_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) begin
               $error("unexpected response: left_out %0d right_out %0d muted %0d",
                      rsp_data.left_out, rsp_data.right_out, rsp_data.muted);
            end
         end else begin
            want = pair_expect_q.pop_front();
            if (rsp_data.left_out !== want.left_out) begin
               fail_count++;
               if (fail_count <= REPORT_CAP) begin
                  $error("left_out: expected %0d, got %0d", want.left_out, rsp_data.left_out);
               end
            end
            if (rsp_data.right_out !== want.right_out) begin
               fail_count++;
               if (fail_count <= REPORT_CAP) begin
                  $error("right_out: expected %0d, got %0d",
                         want.right_out, rsp_data.right_out);
               end
            end
            if (rsp_data.muted !== want.muted) begin
               fail_count++;
               if (fail_count <= REPORT_CAP) begin
                  $error("muted: expected %0d, got %0d", want.muted, rsp_data.muted);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      ssmr_req_type r;
      logic         counted;
      int           sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      ramp_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         // sender pauses until every pending pair is back
         req_valid = 1'b0;
         wait_drained();
         send_idle_pct = SEND_IDLE_PCT[ph];
         rsp_stall_pct = RSP_STALL_PCT[ph];
         if (ph == 0 || ph == 2) hold_req++;
         sent = 0;
         while (sent < RAND_ITEMS / PHASES) begin
            pick_random_req(r, counted);
            send_req(r, 1'b0, '0);
            if (counted) sent++;
         end
      end

      req_valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pair_expect_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== scheduled_stereo_mute_ramp.f =====
rtl/core/ssmr_pkg.sv
rtl/core/ssmr_lane.sv
rtl/core/ssmr_ctrl.sv
rtl/core/scheduled_stereo_mute_ramp.sv
sim/tb.sv
